// ===== rtl/qss_pkg.sv =====
// Package: shared constants and types of the quicksort sort engine.
`default_nettype none
package qss_pkg;
    localparam int MAX_ELEMENTS = 64;
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = AW + 1;
    localparam int DW = 32;
    localparam int SW = 2 * AW;
endpackage
`default_nettype wire

// ===== rtl/qss_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module qss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/quicksort_sort_engine.sv =====
// Top level: quicksort engine with element and range memories.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+---------------------------
//  in item  | i_value, i_last              | start high, busy low
//  result   | o_value_res, o_last_res      | o_valid strobe, one cycle
//
// Loading accepts one item per cycle while start is high and busy low. After the
// item marked last the block sorts in place through the one element memory port:
// a partition compares each element with the pivot, the last of its range, swaps
// those not above it into place, then places the pivot. Sorted input is the slow
// case. Results never come back to back. busy rises after the item marked last
// and falls as the final result appears. Reset is synchronous, active low;
// memory contents are undefined until written. The receiver cannot stall.
`default_nettype none
module quicksort_sort_engine
    import qss_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [DW-1:0] i_value,
    input  wire logic          i_last,
    output logic               o_valid,
    output logic [DW-1:0]      o_value_res,
    output logic               o_last_res
);
    typedef enum logic [4:0] {
        S_LOAD, S_POP, S_POPW, S_PIVR, S_PIVW, S_KRD, S_KW, S_DRD, S_DW,
        S_SWK, S_SWD, S_FRD, S_FW, S_FHI, S_FDST, S_OUTR, S_OUTW
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count, r_sp;
    logic [AW-1:0] r_lo, r_hi, r_k, r_dst, r_oi;
    logic [DW-1:0] r_pivot, r_kv;

    logic          em_we, st_we;
    logic [AW-1:0] em_addr, st_addr;
    logic [DW-1:0] em_wdata, em_rdata;
    logic [SW-1:0] st_wdata, st_rdata;

    qss_ram #(.WIDTH(DW), .DEPTH(MAX_ELEMENTS)) u_elem (
        .i_clk(i_clk), .i_we(em_we), .i_addr(em_addr),
        .i_wdata(em_wdata), .o_rdata(em_rdata)
    );
    qss_ram #(.WIDTH(SW), .DEPTH(MAX_ELEMENTS)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_addr(st_addr),
        .i_wdata(st_wdata), .o_rdata(st_rdata)
    );

    logic [AW-1:0] mid_lo, mid_hi;
    logic [CW-1:0] spm1;
    logic          push_l, push_r;
    assign spm1 = r_sp - CW'(1);

    // Memory port control per state.
    always_comb begin
        em_we    = 1'b0;
        em_addr  = r_k;
        em_wdata = r_kv;
        case (r_state)
            S_LOAD: begin
                em_we    = start && r_count != CW'(MAX_ELEMENTS);
                em_addr  = r_count[AW-1:0];
                em_wdata = i_value;
            end
            S_PIVR:  em_addr = r_hi;
            S_KRD:   em_addr = r_k;
            S_DRD:   em_addr = r_dst;
            // Hold the dst address so its element is on the port in S_SWK.
            S_DW:    em_addr = r_dst;
            S_SWK: begin
                em_we = 1'b1; em_addr = r_k; em_wdata = em_rdata;
            end
            S_SWD: begin
                em_we = 1'b1; em_addr = r_dst; em_wdata = r_kv;
            end
            S_FRD:   em_addr = r_dst;
            S_FHI: begin
                em_we = 1'b1; em_addr = r_hi; em_wdata = r_kv;
            end
            S_FDST: begin
                em_we = 1'b1; em_addr = r_dst; em_wdata = r_pivot;
            end
            S_OUTR:  em_addr = r_oi;
            default: em_addr = r_k;
        endcase
    end

    assign mid_lo = r_dst - AW'(1);
    assign mid_hi = r_dst + AW'(1);

    // Sub-ranges of two or more elements are kept; only the left one is written to the stack.
    assign push_l = (r_state == S_FDST) && ({1'b0, r_dst} > {1'b0, r_lo} + CW'(1));
    assign push_r = ({1'b0, r_dst} + CW'(1)) < {1'b0, r_hi};

    // Stack port: write the left range in S_FDST, otherwise read the top.
    assign st_we    = push_l;
    assign st_addr  = push_l ? r_sp[AW-1:0] : spm1[AW-1:0];
    assign st_wdata = {r_lo, mid_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_sp    <= '0;
            busy    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (start) begin
                        if (r_count != CW'(MAX_ELEMENTS)) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_last) begin
                            busy <= 1'b1;
                            // Seed the stack with the whole range when it
                            // holds two or more elements.
                            r_oi <= '0;
                            if (r_count >= CW'(1) && r_count != CW'(MAX_ELEMENTS)) begin
                                r_lo    <= '0;
                                r_hi    <= r_count[AW-1:0];
                                r_sp    <= CW'(1);
                                r_state <= S_PIVR;
                            end else if (r_count == CW'(MAX_ELEMENTS)) begin
                                r_lo    <= '0;
                                r_hi    <= AW'(MAX_ELEMENTS - 1);
                                r_sp    <= CW'(1);
                                r_state <= S_PIVR;
                            end else begin
                                r_state <= S_OUTR;
                            end
                        end
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_oi    <= '0;
                        r_state <= S_OUTR;
                    end else begin
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    {r_lo, r_hi} <= st_rdata;
                    r_state      <= S_PIVR;
                end
                S_PIVR: begin
                    // Pop the range just taken.
                    r_sp    <= spm1;
                    r_state <= S_PIVW;
                end
                S_PIVW: begin
                    r_pivot <= em_rdata;
                    r_k     <= r_lo;
                    r_dst   <= r_lo;
                    r_state <= (r_lo == r_hi) ? S_FRD : S_KRD;
                end
                S_KRD: r_state <= S_KW;
                S_KW: begin
                    r_kv <= em_rdata;
                    if ($signed(em_rdata) <= $signed(r_pivot)) begin
                        r_state <= S_DRD;
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_state <= (r_k + AW'(1) == r_hi) ? S_FRD : S_KRD;
                    end
                end
                S_DRD: r_state <= S_DW;
                S_DW:  r_state <= S_SWK;
                S_SWK: r_state <= S_SWD;
                S_SWD: begin
                    r_dst   <= r_dst + AW'(1);
                    r_k     <= r_k + AW'(1);
                    r_state <= (r_k + AW'(1) == r_hi) ? S_FRD : S_KRD;
                end
                S_FRD: r_state <= S_FW;
                S_FW: begin
                    r_kv    <= em_rdata;
                    r_state <= S_FHI;
                end
                S_FHI: r_state <= S_FDST;
                S_FDST: begin
                    // Push left then right; the right range is the next one
                    // popped, so take it at once instead of reading it back.
                    r_sp <= r_sp + CW'(push_l) + CW'(push_r);
                    if (push_r) begin
                        r_lo    <= mid_hi;
                        r_state <= S_PIVR;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_OUTR: begin
                    if (r_count == '0) begin
                        busy    <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_OUTW;
                    end
                end
                S_OUTW: begin
                    o_valid     <= 1'b1;
                    o_value_res <= em_rdata;
                    o_last_res  <= ({1'b0, r_oi} + CW'(1) == r_count);
                    if ({1'b0, r_oi} + CW'(1) == r_count) begin
                        r_count <= '0;
                        r_sp    <= '0;
                        busy    <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_oi    <= r_oi + AW'(1);
                        r_state <= S_OUTR;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/qss_checker.sv =====
// Port-level checker for the quicksort sort engine, bound to the top level.
`default_nettype none
module qss_checker
    import qss_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_last,
    input wire logic o_valid,
    input wire logic o_last_res
);
    a_no_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result while idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_res) |-> !busy) else $error("busy after last result");
    a_busy_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy) else $error("no busy after last item");
endmodule
bind quicksort_sort_engine qss_checker u_qss_checker (.*);
`default_nettype wire
